@@ hdl/adcv_pkg.sv @@
package adcv_pkg;

    // lcd serial frame sync bytes
    localparam logic [7:0] SYNC_CMD       = 8'hF8;
    localparam logic [7:0] SYNC_DATA      = 8'hFA;
    localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;

    // display address after reset
    localparam logic [7:0] ADDR_RESET = 8'h92;

    // ascii characters of the voltage text
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_VOLT = 8'h56;

    // digit queue between front and back (depth of at least two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one display update: volts, tenths and hundredths digits
    typedef struct packed {
        logic [3:0] ones;
        logic [3:0] tenths;
        logic [3:0] hundredths;
    } digits_t;

endpackage

@@ hdl/adcv_in_if.sv @@
interface adcv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ hdl/adcv_out_if.sv @@
interface adcv_out_if;
    logic        valid;
    logic        ready;
    logic        is_data;
    logic [7:0]  payload;
    logic [23:0] frame_word;
    logic        last_of_run;

    modport source (output valid, output is_data, output payload, output frame_word,
                    output last_of_run, input ready);
    modport sink (input valid, input is_data, input payload, input frame_word,
                  input last_of_run, output ready);
endinterface

@@ hdl/adcv_front.sv @@
module adcv_front
    import adcv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    adcv_in_if.sink   samples,
    output logic      push,
    output digits_t   push_data,
    input  logic      full
);

    // stage valids: a product, b reciprocal, c correction, d ones, e remainder, f tenths
    logic [5:0] v_reg;
    logic       advance;
    logic       accept;
    logic       changed;

    logic [7:0] last_shown_reg;
    logic       shown_valid_reg;

    logic [16:0] x_next;
    logic [16:0] x_a_reg;
    logic [24:0] recip_prod;
    logic [8:0]  q_next;
    logic [16:0] x_b_reg;
    logic [8:0]  q_b_reg;
    logic [16:0] resid;
    logic [8:0]  hund_next;
    logic [8:0]  hund_c_reg;
    logic [14:0] ones_prod;
    logic [2:0]  ones_next;
    logic [8:0]  hund_d_reg;
    logic [2:0]  ones_d_reg;
    logic [6:0]  rem_next;
    logic [2:0]  ones_e_reg;
    logic [6:0]  rem_e_reg;
    logic [14:0] tenths_prod;
    logic [3:0]  tenths_next;
    logic [2:0]  ones_f_reg;
    logic [6:0]  rem_f_reg;
    logic [3:0]  tenths_f_reg;

    assign advance       = !v_reg[5] || !full;
    assign samples.ready = advance;
    assign accept        = samples.valid && advance;
    assign changed       = !shown_valid_reg || (samples.sample != last_shown_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg           <= '0;
            last_shown_reg  <= '0;
            shown_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && changed)
            begin
                last_shown_reg  <= samples.sample;
                shown_valid_reg <= 1'b1;
            end
            if (advance)
            begin
                v_reg <= {v_reg[4:0], accept && changed};
            end
        end
    end

    // floor(s*500/255) by reciprocal 257/65536 and one correction step,
    // then the digits by reciprocals of 100 and 10
    always_comb
    begin
        x_next      = 17'(samples.sample) * 17'd500;
        recip_prod  = 25'(x_a_reg) * 25'd257;
        q_next      = recip_prod[24:16];
        resid       = x_b_reg - 17'(q_b_reg) * 17'd255;
        hund_next   = (resid >= 17'd255) ? q_b_reg + 9'd1 : q_b_reg;
        ones_prod   = 15'(hund_c_reg) * 15'd41;
        ones_next   = ones_prod[14:12];
        rem_next    = 7'(hund_d_reg - 9'(ones_d_reg) * 9'd100);
        tenths_prod = 15'(rem_e_reg) * 15'd205;
        tenths_next = tenths_prod[14:11];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_a_reg      <= x_next;
            x_b_reg      <= x_a_reg;
            q_b_reg      <= q_next;
            hund_c_reg   <= hund_next;
            hund_d_reg   <= hund_c_reg;
            ones_d_reg   <= ones_next;
            ones_e_reg   <= ones_d_reg;
            rem_e_reg    <= rem_next;
            ones_f_reg   <= ones_e_reg;
            rem_f_reg    <= rem_e_reg;
            tenths_f_reg <= tenths_next;
        end
    end

    assign push                 = v_reg[5] && !full;
    assign push_data.ones       = 4'(ones_f_reg);
    assign push_data.tenths     = tenths_f_reg;
    assign push_data.hundredths = 4'(rem_f_reg - 7'(tenths_f_reg) * 7'd10);

    // an unchanged sample must not start an update
    a_skip_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready && shown_valid_reg &&
        (samples.sample == last_shown_reg) |=> !v_reg[0])
        else $error("unchanged sample entered the pipeline");

    // digits leaving the arithmetic are decimal, with the volts digit at most 5
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data.ones <= 4'd5) && (push_data.tenths <= 4'd9) &&
        (push_data.hundredths <= 4'd9))
        else $error("digit out of range");

endmodule

@@ hdl/adcv_queue.sv @@
module adcv_queue
    import adcv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  digits_t push_data,
    output logic    full,
    output logic    head_valid,
    output digits_t head_data,
    input  logic    pop
);

    digits_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("pop from empty queue");

endmodule

@@ hdl/adcv_back.sv @@
module adcv_back
    import adcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       head_valid,
    input  digits_t    head_data,
    output logic       pop,
    adcv_out_if.source writes
);

    localparam logic [2:0] STEP_CMD        = 3'd0;
    localparam logic [2:0] STEP_ONES       = 3'd1;
    localparam logic [2:0] STEP_DOT        = 3'd2;
    localparam logic [2:0] STEP_TENTHS     = 3'd3;
    localparam logic [2:0] STEP_HUNDREDTHS = 3'd4;
    localparam logic [2:0] STEP_VOLT       = 3'd5;

    logic [7:0]  address_reg;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic        out_valid_reg;
    logic        is_data_reg;
    logic [7:0]  payload_reg;
    logic [23:0] frame_reg;
    logic        last_reg;

    logic        load;
    logic        is_data_next;
    logic [7:0]  payload_next;
    logic [23:0] frame_next;
    logic        last_next;

    assign load = head_valid && (!out_valid_reg || writes.ready);
    assign pop  = load && (step_reg == STEP_VOLT);

    always_comb
    begin
        is_data_next = 1'b1;
        payload_next = CHAR_VOLT;
        last_next    = 1'b0;
        step_next    = STEP_CMD;
        unique case (step_reg)
            STEP_CMD:
            begin
                is_data_next = 1'b0;
                payload_next = address_reg;
                step_next    = STEP_ONES;
            end
            STEP_ONES:
            begin
                payload_next = CHAR_ZERO + 8'(head_data.ones);
                step_next    = STEP_DOT;
            end
            STEP_DOT:
            begin
                payload_next = CHAR_DOT;
                step_next    = STEP_TENTHS;
            end
            STEP_TENTHS:
            begin
                payload_next = CHAR_ZERO + 8'(head_data.tenths);
                step_next    = STEP_HUNDREDTHS;
            end
            STEP_HUNDREDTHS:
            begin
                payload_next = CHAR_ZERO + 8'(head_data.hundredths);
                step_next    = STEP_VOLT;
            end
            STEP_VOLT:
            begin
                payload_next = CHAR_VOLT;
                last_next    = 1'b1;
                step_next    = STEP_CMD;
            end
            default:
            begin
                is_data_next = 1'b0;
                payload_next = address_reg;
                step_next    = STEP_CMD;
            end
        endcase
        frame_next = {is_data_next ? SYNC_DATA : SYNC_CMD,
                      payload_next & HI_NIBBLE_MASK,
                      payload_next[3:0], 4'b0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg   <= ADDR_RESET;
            step_reg      <= STEP_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                address_reg <= cfg_wr_data;
            end
            if (load)
            begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (writes.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_data_reg <= is_data_next;
            payload_reg <= payload_next;
            frame_reg   <= frame_next;
            last_reg    <= last_next;
        end
    end

    assign writes.valid       = out_valid_reg;
    assign writes.is_data     = is_data_reg;
    assign writes.payload     = payload_reg;
    assign writes.frame_word  = frame_reg;
    assign writes.last_of_run = last_reg;

    // after a run is retired the next write is the address command
    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (step_reg == STEP_CMD))
        else $error("sequencer did not restart after last write");

    a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_data_reg |-> !last_reg)
        else $error("command write flagged as last of run");

endmodule

@@ hdl/adc_voltage_to_lcd_frames.sv @@
// channel   dir  payload                                      transfer when
// samples   in   sample[7:0]                                  valid && ready
// writes    out  is_data, payload[7:0], frame_word[23:0],     valid && ready
//                last_of_run
// cfg       in   cfg_wr_data[7:0] (display address)           cfg_wr_en
//
// a changed sample yields six writes, one per cycle while writes.ready holds; the update rate
// is set by the single output register of the write sequencer
// an unchanged sample is dropped
// the first write of an update follows the sample transfer through the 6-stage arithmetic,
// the digit queue and the output register
// rst_n is asynchronous: nothing shown yet, display address back to 0x92
// the front keeps taking samples while writes stall until its pipeline and queue are full
module adc_voltage_to_lcd_frames
    import adcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    adcv_in_if.sink    samples,
    adcv_out_if.source writes,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    // front to queue
    logic    push;
    digits_t push_data;
    logic    full;

    // queue to back
    logic    head_valid;
    digits_t head_data;
    logic    pop;

    // front: change detect against the last shown sample, then the fixed-point
    // hundredths of a volt and its three decimal digits in a stalling pipeline
    adcv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // short digit queue so that the arithmetic and the write sequencer stall independently
    adcv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // back: steps through address command, digit, dot, digit, digit, 'V' and builds
    // each serial frame into the output register; holds the display address register
    adcv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .writes      (writes)
    );

endmodule

@@ tb/adc_voltage_to_lcd_frames_tb.sv @@
module adc_voltage_to_lcd_frames_tb;
    import adcv_pkg::*;

    // cycles with no transfer at all before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // quiet cycles after the last expected write: pipeline, digit queue, output register
    localparam int SETTLE_CYCLES = 30;
    localparam int SHOWN_ERRORS  = 10;
    localparam int RANDOM_RUNS   = 90;

    // how a stimulus row is handled
    typedef enum logic [1:0] {
        ROW_PREDICT,  // expected writes come from the predictor
        ROW_TEXT,     // expected characters typed into the row
        ROW_SILENT,   // typed: the sample is already shown, no writes
        ROW_ADDR      // write the display address register
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  value;
        logic [39:0] text;
    } stim_row_t;

    // one lcd write as seen on the output channel
    typedef struct packed {
        logic        is_data;
        logic [7:0]  payload;
        logic [23:0] frame_word;
        logic        last_of_run;
    } lcd_write_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [7:0] cfg_wr_data;

    adcv_in_if  sample_ch ();
    adcv_out_if write_ch ();

    adc_voltage_to_lcd_frames u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .writes      (write_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor copy of the block state and its one register
    logic [7:0] disp_addr;
    logic [7:0] last_shown;
    logic       shown_valid;

    // writes still owed by the block, oldest first
    lcd_write_t owed_writes[$];

    int error_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    stim_row_t directed_rows[20];

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // build one write: sync byte, high nibble, low nibble moved up
    function automatic lcd_write_t lcd_write(input logic is_data, input logic [7:0] b,
                                             input logic last_of_run);
        lcd_write_t w;
        w.is_data     = is_data;
        w.payload     = b;
        w.frame_word  = {(is_data ? SYNC_DATA : SYNC_CMD), b & HI_NIBBLE_MASK, {b[3:0], 4'h0}};
        w.last_of_run = last_of_run;
        return w;
    endfunction

    // five characters "d.ddV" for a sample, hundredths of a volt rounded down
    function automatic logic [39:0] voltage_text(input logic [7:0] s);
        int hund;
        hund = int'(s) * 500 / 255;
        return {CHAR_ZERO + 8'(hund / 100), CHAR_DOT, CHAR_ZERO + 8'((hund % 100) / 10),
                CHAR_ZERO + 8'(hund % 10), CHAR_VOLT};
    endfunction

    // address command then the five characters, last one closes the run
    function automatic void owe_update_run(input logic [39:0] text);
        owed_writes.push_back(lcd_write(1'b0, disp_addr, 1'b0));
        for (int i = 0; i < 5; i++)
            owed_writes.push_back(lcd_write(1'b1, text[39 - 8 * i -: 8], i == 4));
    endfunction

    // ------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------

    // one sample transfer; on acceptance the owed writes are queued
    task automatic transfer_sample(input logic [7:0] s, input row_kind_t kind,
                                   input logic [39:0] text, output bit changed);
        // random sender gaps, with junk on the data lines
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= 8'($urandom);
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        // accepted at this edge
        changed = !shown_valid || (s != last_shown);
        if (kind == ROW_TEXT)
            owe_update_run(text);
        else if (kind == ROW_PREDICT && changed)
            owe_update_run(voltage_text(s));
        if (changed)
        begin
            last_shown  = s;
            shown_valid = 1'b1;
        end
    endtask

    // hold the sender until every owed write has come out
    task automatic wait_for_writes();
        sample_ch.valid <= 1'b0;
        while (owed_writes.size() != 0)
            @(posedge clk);
    endtask

    // register write only with the block idle: drained, plus time for a dropped sample
    task automatic set_display_address(input logic [7:0] v);
        wait_for_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        disp_addr = v;
    endtask

    // random samples: repeats, neighbors of the shown value for digit carries, and
    // uniform values; runs until enough updates went through
    task automatic random_phase(input int send_pct, input int recv_pct, input logic [7:0] addr);
        int updates;
        int pick;
        logic [7:0] s;
        bit changed;
        updates = 0;
        set_display_address(addr);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (updates < RANDOM_RUNS)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                s = last_shown;
            else if (pick < 40)
                s = pick[0] ? last_shown + 8'd1 : last_shown - 8'd1;
            else
                s = 8'($urandom);
            transfer_sample(s, ROW_PREDICT, 40'd0, changed);
            if (changed)
            begin
                updates++;
                // sender backs off until the display catches up
                if (updates == 40 || $urandom_range(59) == 0)
                    wait_for_writes();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // write side: random stalls and checking
    // ------------------------------------------------------------------

    task automatic report_write(input string what, input lcd_write_t e, input lcd_write_t g);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
        begin
            $display("%s: expected is_data=%0b payload=%02h frame=%06h last=%0b,",
                     what, e.is_data, e.payload, e.frame_word, e.last_of_run);
            $display("    got is_data=%0b payload=%02h frame=%06h last=%0b",
                     g.is_data, g.payload, g.frame_word, g.last_of_run);
        end
    endtask

    always @(posedge clk)
        write_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    lcd_write_t got_write;
    lcd_write_t exp_write;

    // compare each write transfer with the oldest owed write
    always @(posedge clk)
    begin
        if (rst_n && write_ch.valid && write_ch.ready)
        begin
            got_write = '{write_ch.is_data, write_ch.payload, write_ch.frame_word,
                          write_ch.last_of_run};
            if (owed_writes.size() == 0)
                report_write("write with none owed", '0, got_write);
            else
            begin
                exp_write = owed_writes.pop_front();
                if (got_write.is_data !== exp_write.is_data
                    || got_write.payload !== exp_write.payload
                    || got_write.frame_word !== exp_write.frame_word
                    || got_write.last_of_run !== exp_write.last_of_run)
                    report_write("write mismatch", exp_write, got_write);
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (write_ch.valid && write_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("** adc_voltage_to_lcd_frames: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        bit changed;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 8'd0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = 8'd0;
        write_ch.ready   = 1'b0;
        error_count      = 0;
        quiet_cycles     = 0;
        send_idle_pct    = 27;
        recv_idle_pct    = 46;
        disp_addr        = ADDR_RESET;
        last_shown       = 8'd0;
        shown_valid      = 1'b0;

        // directed rows, reset address first
        directed_rows = '{
            '{ROW_TEXT,    8'd0,   "0.00V"},  // first sample equals the reset state, still shown
            '{ROW_SILENT,  8'd0,   40'd0},    // unchanged, dropped
            '{ROW_TEXT,    8'd255, "5.00V"},  // full scale
            '{ROW_SILENT,  8'd255, 40'd0},
            '{ROW_PREDICT, 8'd1,   40'd0},
            '{ROW_PREDICT, 8'd254, 40'd0},
            '{ROW_ADDR,    8'h00,  40'd0},    // address below the ddram range goes out as is
            '{ROW_PREDICT, 8'd128, 40'd0},
            '{ROW_PREDICT, 8'd127, 40'd0},
            '{ROW_SILENT,  8'd127, 40'd0},
            '{ROW_TEXT,    8'd0,   "0.00V"},
            '{ROW_ADDR,    8'hFF,  40'd0},
            '{ROW_TEXT,    8'd255, "5.00V"},
            '{ROW_PREDICT, 8'd51,  40'd0},
            '{ROW_PREDICT, 8'd102, 40'd0},
            '{ROW_PREDICT, 8'hAA,  40'd0},
            '{ROW_PREDICT, 8'h55,  40'd0},
            '{ROW_ADDR,    8'h80,  40'd0},
            '{ROW_PREDICT, 8'd200, 40'd0},
            '{ROW_SILENT,  8'd200, 40'd0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_ADDR)
                set_display_address(directed_rows[i].value);
            else
                transfer_sample(directed_rows[i].value, directed_rows[i].kind,
                                directed_rows[i].text, changed);
        end

        // receiver idles more first, then the sender, then neither
        random_phase(27, 46, 8'($urandom));
        random_phase(46, 27, 8'h7F);
        random_phase(0, 0, 8'($urandom));

        // drain, then give the block time to show anything unexpected
        wait_for_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && owed_writes.size() == 0)
            $display("** adc_voltage_to_lcd_frames: PASSED **");
        else
            $display("** adc_voltage_to_lcd_frames: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/adcv_pkg.sv
hdl/adcv_in_if.sv
hdl/adcv_out_if.sv
hdl/adcv_front.sv
hdl/adcv_queue.sv
hdl/adcv_back.sv
hdl/adc_voltage_to_lcd_frames.sv
tb/adc_voltage_to_lcd_frames_tb.sv
